// File: hdl/gmg_pkg.sv
// Package: shared types, constants and codes of the topic model Gibbs sampler.
`timescale 1ns / 1ps
package gmg_pkg;

	localparam int MAX_TOPICS_DEF  = 64;
	localparam int MAX_DOCS_DEF    = 1024;
	localparam int DEP_VOCAB_DEF   = 4096;
	localparam int GOV_VOCAB_DEF   = 4096;
	localparam int COUNT_WIDTH_DEF = 20;

	localparam int CFG_DW   = 24;
	localparam int CFG_IW   = 3;
	localparam int DENW     = 41;   // (total << 16) + vsize * beta
	localparam int TOT_W    = 24;
	localparam int W48      = 48;
	localparam int TOPIC_W  = 6;
	localparam int DOC_W    = 10;
	localparam int WORD_W   = 12;
	localparam int DRAW_W   = 32;
	localparam int NTOP_W   = 7;
	localparam int VSIZE_W  = 13;

	typedef enum logic [CFG_IW-1:0] {
		CFG_ALPHA     = 3'd0,
		CFG_BETA_DEP  = 3'd1,
		CFG_BETA_GOV  = 3'd2,
		CFG_NUM_TOP   = 3'd3,
		CFG_DEP_VSIZE = 3'd4,
		CFG_GOV_VSIZE = 3'd5
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_MOD1, ST_MOD2, ST_REM_RD, ST_REM_WR,
		ST_K_RD, ST_K_LD, ST_K_DIV, ST_MUL1, ST_MUL2, ST_ACC,
		ST_THR1, ST_THR2, ST_SC_RD, ST_SC_CMP, ST_ADD_RD, ST_ADD_WR, ST_OUT
	} gmg_state_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_CLEAR, OP_CAPTURE, OP_MOD1, OP_MOD2, OP_REM_RD, OP_REM_WR,
		OP_K_RD, OP_K_LD, OP_MUL1, OP_MUL2, OP_ACC, OP_THR1, OP_THR2,
		OP_SC_RD, OP_SC_CMP, OP_ADD_RD, OP_ADD_WR, OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} gmg_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic mode;
		logic div_done;
		logic k_last;
		logic hit;
		logic out_free;
	} gmg_status_t;

endpackage

// File: hdl/gmg_if.sv
// Interfaces: token channel and result channel, valid/ready.
`timescale 1ns / 1ps
interface gmg_token_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [gmg_pkg::DOC_W-1:0]   doc_index;
	logic [gmg_pkg::WORD_W-1:0]  dependent_word;
	logic [gmg_pkg::WORD_W-1:0]  governor_word;
	logic [gmg_pkg::TOPIC_W-1:0] current_topic;
	logic [gmg_pkg::DRAW_W-1:0]  random_draw;

	modport source (output valid, mode, doc_index, dependent_word, governor_word,
		current_topic, random_draw, input ready);
	modport sink (input valid, mode, doc_index, dependent_word, governor_word,
		current_topic, random_draw, output ready);
endinterface

interface gmg_result_if;
	logic                        valid;
	logic                        ready;
	logic [gmg_pkg::TOPIC_W-1:0] new_topic;
	logic                        underflow;

	modport source (output valid, new_topic, underflow, input ready);
	modport sink (input valid, new_topic, underflow, output ready);
endinterface

// File: hdl/gmg_divider.sv
// Restoring divider: 16 quotient bits of (num << 16) / den, one bit per cycle.
`timescale 1ns / 1ps
module gmg_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [gmg_pkg::DENW-1:0]  num,
	input  logic [gmg_pkg::DENW-1:0]  den,
	output logic [15:0]               quo,
	output logic                      done
);
	logic [gmg_pkg::DENW-1:0] rem_q, den_q;
	logic [15:0]              quo_q;
	logic [3:0]               cnt_q;
	logic                     busy_q, done_q;
	logic [gmg_pkg::DENW:0]   rem2;
	logic                     qbit;

	always_comb begin
		rem2 = {rem_q, 1'b0};
		qbit = (rem2 >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd15) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= qbit ? gmg_pkg::DENW'(rem2 - {1'b0, den_q})
				: rem2[gmg_pkg::DENW-1:0];
			quo_q <= {quo_q[14:0], qbit};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;
endmodule

// File: hdl/gmg_ctrl.sv
// Controller: sequences the table clear, capture, count updates, topic weighing and the draw.
`timescale 1ns / 1ps
module gmg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tok_valid,
	output logic                 tok_ready,
	input  gmg_pkg::gmg_status_t status,
	output gmg_pkg::gmg_cmd_t    cmd
);
	gmg_pkg::gmg_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= gmg_pkg::ST_CLEAR;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd.op    = gmg_pkg::OP_NOP;
		tok_ready = 1'b0;
		case (state_q)
			gmg_pkg::ST_CLEAR: begin
				cmd.op = gmg_pkg::OP_CLEAR;
				if (status.clr_last) state_d = gmg_pkg::ST_IDLE;
			end
			gmg_pkg::ST_IDLE: begin
				tok_ready = 1'b1;
				if (tok_valid) begin
					cmd.op  = gmg_pkg::OP_CAPTURE;
					state_d = gmg_pkg::ST_MOD1;
				end
			end
			gmg_pkg::ST_MOD1: begin
				cmd.op  = gmg_pkg::OP_MOD1;
				state_d = gmg_pkg::ST_MOD2;
			end
			gmg_pkg::ST_MOD2: begin
				cmd.op  = gmg_pkg::OP_MOD2;
				state_d = status.mode ? gmg_pkg::ST_REM_RD : gmg_pkg::ST_ADD_RD;
			end
			gmg_pkg::ST_REM_RD: begin
				cmd.op  = gmg_pkg::OP_REM_RD;
				state_d = gmg_pkg::ST_REM_WR;
			end
			gmg_pkg::ST_REM_WR: begin
				cmd.op  = gmg_pkg::OP_REM_WR;
				state_d = gmg_pkg::ST_K_RD;
			end
			gmg_pkg::ST_K_RD: begin
				cmd.op  = gmg_pkg::OP_K_RD;
				state_d = gmg_pkg::ST_K_LD;
			end
			gmg_pkg::ST_K_LD: begin
				cmd.op  = gmg_pkg::OP_K_LD;
				state_d = gmg_pkg::ST_K_DIV;
			end
			gmg_pkg::ST_K_DIV: begin
				if (status.div_done) state_d = gmg_pkg::ST_MUL1;
			end
			gmg_pkg::ST_MUL1: begin
				cmd.op  = gmg_pkg::OP_MUL1;
				state_d = gmg_pkg::ST_MUL2;
			end
			gmg_pkg::ST_MUL2: begin
				cmd.op  = gmg_pkg::OP_MUL2;
				state_d = gmg_pkg::ST_ACC;
			end
			gmg_pkg::ST_ACC: begin
				cmd.op  = gmg_pkg::OP_ACC;
				state_d = status.k_last ? gmg_pkg::ST_THR1 : gmg_pkg::ST_K_RD;
			end
			gmg_pkg::ST_THR1: begin
				cmd.op  = gmg_pkg::OP_THR1;
				state_d = gmg_pkg::ST_THR2;
			end
			gmg_pkg::ST_THR2: begin
				cmd.op  = gmg_pkg::OP_THR2;
				state_d = gmg_pkg::ST_SC_RD;
			end
			gmg_pkg::ST_SC_RD: begin
				cmd.op  = gmg_pkg::OP_SC_RD;
				state_d = gmg_pkg::ST_SC_CMP;
			end
			gmg_pkg::ST_SC_CMP: begin
				cmd.op  = gmg_pkg::OP_SC_CMP;
				state_d = (status.hit || status.k_last) ? gmg_pkg::ST_ADD_RD
					: gmg_pkg::ST_SC_RD;
			end
			gmg_pkg::ST_ADD_RD: begin
				cmd.op  = gmg_pkg::OP_ADD_RD;
				state_d = gmg_pkg::ST_ADD_WR;
			end
			gmg_pkg::ST_ADD_WR: begin
				cmd.op  = gmg_pkg::OP_ADD_WR;
				state_d = gmg_pkg::ST_OUT;
			end
			gmg_pkg::ST_OUT: begin
				if (status.out_free) begin
					cmd.op  = gmg_pkg::OP_OUT;
					state_d = gmg_pkg::ST_IDLE;
				end
			end
			default: state_d = gmg_pkg::ST_CLEAR;
		endcase
	end
endmodule

// File: hdl/gmg_datapath.sv
// Datapath: config registers, count memories, ratio dividers, weights and draw.
`timescale 1ns / 1ps
module gmg_datapath #(
	parameter int MAX_TOPICS  = gmg_pkg::MAX_TOPICS_DEF,
	parameter int MAX_DOCS    = gmg_pkg::MAX_DOCS_DEF,
	parameter int DEP_VOCAB   = gmg_pkg::DEP_VOCAB_DEF,
	parameter int GOV_VOCAB   = gmg_pkg::GOV_VOCAB_DEF,
	parameter int COUNT_WIDTH = gmg_pkg::COUNT_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gmg_pkg::gmg_cmd_t            cmd,
	output gmg_pkg::gmg_status_t         status,
	input  logic                         cfg_we,
	input  logic [gmg_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [gmg_pkg::CFG_DW-1:0]   cfg_wdata,
	input  logic                         tok_mode,
	input  logic [gmg_pkg::DOC_W-1:0]    tok_doc,
	input  logic [gmg_pkg::WORD_W-1:0]   tok_dep,
	input  logic [gmg_pkg::WORD_W-1:0]   tok_gov,
	input  logic [gmg_pkg::TOPIC_W-1:0]  tok_topic,
	input  logic [gmg_pkg::DRAW_W-1:0]   tok_draw,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [gmg_pkg::TOPIC_W-1:0]  res_topic,
	output logic                         res_under
);
	localparam int TW        = $clog2(MAX_TOPICS);
	localparam int DOCW      = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
	localparam int DEPW      = $clog2(DEP_VOCAB);
	localparam int GOVW      = $clog2(GOV_VOCAB);
	localparam int DOC_DEPTH = MAX_DOCS * MAX_TOPICS;
	localparam int DEP_DEPTH = MAX_TOPICS * DEP_VOCAB;
	localparam int GOV_DEPTH = MAX_TOPICS * GOV_VOCAB;
	localparam int DOCAW     = $clog2(DOC_DEPTH);
	localparam int DEPAW     = $clog2(DEP_DEPTH);
	localparam int GOVAW     = $clog2(GOV_DEPTH);
	localparam int CLR_A     = (DOC_DEPTH > DEP_DEPTH) ? DOC_DEPTH : DEP_DEPTH;
	localparam int CLR_LEN   = (CLR_A > GOV_DEPTH) ? CLR_A : GOV_DEPTH;
	localparam int CLRW      = $clog2(CLR_LEN);
	localparam int NUMW      = COUNT_WIDTH + 17;
	localparam int CMPW      = (NUMW > gmg_pkg::DENW) ? NUMW : gmg_pkg::DENW;
	localparam int DNHW      = COUNT_WIDTH + 1;
	localparam int PHW       = 17 + DNHW;
	localparam int WTW       = PHW + 1;
	localparam logic [24:0] DOC_RECIP = 25'((1 << 24) / MAX_DOCS);
	localparam logic [24:0] DEP_RECIP = 25'((1 << 24) / DEP_VOCAB);
	localparam logic [24:0] GOV_RECIP = 25'((1 << 24) / GOV_VOCAB);
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
	localparam logic [gmg_pkg::TOT_W-1:0] TOT_MAX = '1;
	localparam logic [gmg_pkg::W48-1:0]   W48_MAX = '1;

	gmg_pkg::dp_op_t op;
	assign op = cmd.op;

	// configuration
	logic [23:0] alpha_q, beta_d_q, beta_g_q;
	logic [gmg_pkg::NTOP_W-1:0]  ntop_q;
	logic [gmg_pkg::VSIZE_W-1:0] vd_q, vg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= 24'd65536;
			beta_d_q <= 24'd6554;
			beta_g_q <= 24'd6554;
			ntop_q   <= 7'd64;
			vd_q     <= 13'd4096;
			vg_q     <= 13'd4096;
		end else if (cfg_we) begin
			case (cfg_index)
				gmg_pkg::CFG_ALPHA:     alpha_q  <= cfg_wdata;
				gmg_pkg::CFG_BETA_DEP:  beta_d_q <= cfg_wdata;
				gmg_pkg::CFG_BETA_GOV:  beta_g_q <= cfg_wdata;
				gmg_pkg::CFG_NUM_TOP:   ntop_q   <= cfg_wdata[gmg_pkg::NTOP_W-1:0];
				gmg_pkg::CFG_DEP_VSIZE: vd_q     <= cfg_wdata[gmg_pkg::VSIZE_W-1:0];
				gmg_pkg::CFG_GOV_VSIZE: vg_q     <= cfg_wdata[gmg_pkg::VSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// topic count and topic clamp at capture
	logic [31:0]   kn, t0w;
	logic [TW-1:0] kmax_c, t0_c;
	always_comb begin
		if (ntop_q == '0)                       kn = 32'd1;
		else if (32'(ntop_q) > 32'(MAX_TOPICS)) kn = 32'(MAX_TOPICS);
		else                                    kn = 32'(ntop_q);
		t0w    = (32'(tok_topic) >= kn) ? kn - 32'd1 : 32'(tok_topic);
		kmax_c = TW'(kn - 32'd1);
		t0_c   = TW'(t0w);
	end

	// captured token and index reduction
	logic                        mode_q;
	logic [gmg_pkg::DOC_W-1:0]   d_raw_q;
	logic [gmg_pkg::WORD_W-1:0]  w_raw_q, g_raw_q;
	logic [gmg_pkg::DRAW_W-1:0]  draw_q;
	logic [TW-1:0]               t0_q, kmax_q, t_cur_q, k_q;
	logic [12:0]                 dq_q, wq_q, gq_q;
	logic [DOCW-1:0]             d_q;
	logic [DEPW-1:0]             w_q;
	logic [GOVW-1:0]             g_q;
	logic [36:0]                 vdb_q, vgb_q;
	logic [31:0]                 dr, wr, gr;

	always_comb begin
		dr = 32'(d_raw_q) - 32'(dq_q) * 32'(MAX_DOCS);
		if (dr >= 32'(MAX_DOCS)) dr = dr - 32'(MAX_DOCS);
		wr = 32'(w_raw_q) - 32'(wq_q) * 32'(DEP_VOCAB);
		if (wr >= 32'(DEP_VOCAB)) wr = wr - 32'(DEP_VOCAB);
		gr = 32'(g_raw_q) - 32'(gq_q) * 32'(GOV_VOCAB);
		if (gr >= 32'(GOV_VOCAB)) gr = gr - 32'(GOV_VOCAB);
	end

	// memories
	logic [COUNT_WIDTH-1:0]    doc_mem [DOC_DEPTH];
	logic [COUNT_WIDTH-1:0]    dep_mem [DEP_DEPTH];
	logic [COUNT_WIDTH-1:0]    gov_mem [GOV_DEPTH];
	logic [gmg_pkg::TOT_W-1:0] dtot_mem [MAX_TOPICS];
	logic [gmg_pkg::TOT_W-1:0] gtot_mem [MAX_TOPICS];
	logic [gmg_pkg::W48-1:0]   cw_mem [MAX_TOPICS];

	logic [COUNT_WIDTH-1:0]    doc_rd_q, dep_rd_q, gov_rd_q;
	logic [gmg_pkg::TOT_W-1:0] dtot_rd_q, gtot_rd_q;
	logic [gmg_pkg::W48-1:0]   cw_rd_q;
	logic [CLRW-1:0]           clr_q;

	logic [TW-1:0] topic_sel;
	logic [31:0]   doc_a, dep_a, gov_a;
	logic          rd_en, clr, rem, add;
	assign topic_sel = (op == gmg_pkg::OP_K_RD) ? k_q : t_cur_q;
	assign doc_a = 32'(d_q) * 32'(MAX_TOPICS) + 32'(topic_sel);
	assign dep_a = 32'(topic_sel) * 32'(DEP_VOCAB) + 32'(w_q);
	assign gov_a = 32'(topic_sel) * 32'(GOV_VOCAB) + 32'(g_q);
	assign rd_en = (op == gmg_pkg::OP_REM_RD) || (op == gmg_pkg::OP_K_RD)
		|| (op == gmg_pkg::OP_ADD_RD);
	assign clr = (op == gmg_pkg::OP_CLEAR);
	assign rem = (op == gmg_pkg::OP_REM_WR);
	assign add = (op == gmg_pkg::OP_ADD_WR);

	function automatic logic [COUNT_WIDTH-1:0] cnt_upd(input logic [COUNT_WIDTH-1:0] c,
		input logic dec);
		if (dec) return (c == '0) ? c : c - 1'b1;
		return (c == CNT_MAX) ? c : c + 1'b1;
	endfunction

	function automatic logic [gmg_pkg::TOT_W-1:0] tot_upd(
		input logic [gmg_pkg::TOT_W-1:0] c, input logic dec);
		if (dec) return (c == '0) ? c : c - 1'b1;
		return (c == TOT_MAX) ? c : c + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (clr && 32'(clr_q) < DOC_DEPTH) doc_mem[clr_q[DOCAW-1:0]] <= '0;
		else if (rem || add) doc_mem[doc_a[DOCAW-1:0]] <= cnt_upd(doc_rd_q, rem);
		if (rd_en) doc_rd_q <= doc_mem[doc_a[DOCAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (clr && 32'(clr_q) < DEP_DEPTH) dep_mem[clr_q[DEPAW-1:0]] <= '0;
		else if (rem || add) dep_mem[dep_a[DEPAW-1:0]] <= cnt_upd(dep_rd_q, rem);
		if (rd_en) dep_rd_q <= dep_mem[dep_a[DEPAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (clr && 32'(clr_q) < GOV_DEPTH) gov_mem[clr_q[GOVAW-1:0]] <= '0;
		else if (rem || add) gov_mem[gov_a[GOVAW-1:0]] <= cnt_upd(gov_rd_q, rem);
		if (rd_en) gov_rd_q <= gov_mem[gov_a[GOVAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (clr && 32'(clr_q) < MAX_TOPICS) dtot_mem[clr_q[TW-1:0]] <= '0;
		else if (rem || add) dtot_mem[topic_sel] <= tot_upd(dtot_rd_q, rem);
		if (rd_en) dtot_rd_q <= dtot_mem[topic_sel];
	end

	always_ff @(posedge clk) begin
		if (clr && 32'(clr_q) < MAX_TOPICS) gtot_mem[clr_q[TW-1:0]] <= '0;
		else if (rem || add) gtot_mem[topic_sel] <= tot_upd(gtot_rd_q, rem);
		if (rd_en) gtot_rd_q <= gtot_mem[topic_sel];
	end

	// ratio numerators and denominators
	logic [CMPW-1:0] num_d, den_d, num_g, den_g;
	always_comb begin
		num_d = CMPW'({dep_rd_q, 16'h0}) + CMPW'(beta_d_q);
		den_d = CMPW'({dtot_rd_q, 16'h0}) + CMPW'(vdb_q);
		num_g = CMPW'({gov_rd_q, 16'h0}) + CMPW'(beta_g_q);
		den_g = CMPW'({gtot_rd_q, 16'h0}) + CMPW'(vgb_q);
	end

	logic [15:0] quo_d, quo_g;
	logic        done_d, done_g, start;
	assign start = (op == gmg_pkg::OP_K_LD);

	gmg_divider u_div_dep (
		.clk(clk), .arst_n(arst_n), .start(start),
		.num(num_d[gmg_pkg::DENW-1:0]), .den(den_d[gmg_pkg::DENW-1:0]),
		.quo(quo_d), .done(done_d)
	);

	gmg_divider u_div_gov (
		.clk(clk), .arst_n(arst_n), .start(start),
		.num(num_g[gmg_pkg::DENW-1:0]), .den(den_g[gmg_pkg::DENW-1:0]),
		.quo(quo_g), .done(done_g)
	);

	// weight and threshold arithmetic
	logic                      zd_q, od_q, zg_q, og_q;
	logic [16:0]               rd, rg, p_q;
	logic [33:0]               pp;
	logic [DNHW-1:0]           dn_hi;
	logic [PHW-1:0]            ph_q;
	logic [32:0]               pl_q;
	logic [WTW-1:0]            wt;
	logic [gmg_pkg::W48-1:0]   wt48, acc_q, acc_new;
	logic [gmg_pkg::W48:0]     acc_sum;
	logic [47:0]               mh_q;
	logic [63:0]               ml_q;
	logic [gmg_pkg::W48:0]     thr_q;

	always_comb begin
		rd = zd_q ? 17'd0 : (od_q ? 17'd65536 : {1'b0, quo_d});
		rg = zg_q ? 17'd0 : (og_q ? 17'd65536 : {1'b0, quo_g});
		pp = 34'(rd) * 34'(rg);
		dn_hi = DNHW'(doc_rd_q) + DNHW'(alpha_q[23:16]);
		wt = WTW'(ph_q) + WTW'(pl_q[32:16]);
		wt48 = (wt > WTW'(W48_MAX)) ? W48_MAX : wt[gmg_pkg::W48-1:0];
		acc_sum = {1'b0, acc_q} + {1'b0, wt48};
		acc_new = acc_sum[gmg_pkg::W48] ? W48_MAX : acc_sum[gmg_pkg::W48-1:0];
	end

	always_ff @(posedge clk) begin
		if (op == gmg_pkg::OP_ACC) cw_mem[k_q] <= acc_new;
		if (op == gmg_pkg::OP_SC_RD) cw_rd_q <= cw_mem[k_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (op)
			gmg_pkg::OP_CAPTURE: begin
				mode_q  <= tok_mode;
				d_raw_q <= tok_doc;
				w_raw_q <= tok_dep;
				g_raw_q <= tok_gov;
				draw_q  <= tok_draw;
				t0_q    <= t0_c;
				kmax_q  <= kmax_c;
			end
			gmg_pkg::OP_MOD1: begin
				dq_q  <= 13'((37'(d_raw_q) * 37'(DOC_RECIP)) >> 24);
				wq_q  <= 13'((37'(w_raw_q) * 37'(DEP_RECIP)) >> 24);
				gq_q  <= 13'((37'(g_raw_q) * 37'(GOV_RECIP)) >> 24);
				vdb_q <= 37'(vd_q) * 37'(beta_d_q);
				vgb_q <= 37'(vg_q) * 37'(beta_g_q);
			end
			gmg_pkg::OP_MOD2: begin
				d_q     <= DOCW'(dr);
				w_q     <= DEPW'(wr);
				g_q     <= GOVW'(gr);
				t_cur_q <= t0_q;
			end
			gmg_pkg::OP_K_LD: begin
				zd_q <= (den_d == '0);
				od_q <= (num_d >= den_d);
				zg_q <= (den_g == '0);
				og_q <= (num_g >= den_g);
			end
			gmg_pkg::OP_MUL1: p_q <= pp[32:16];
			gmg_pkg::OP_MUL2: begin
				ph_q <= PHW'(p_q) * PHW'(dn_hi);
				pl_q <= 33'(p_q) * 33'(alpha_q[15:0]);
			end
			gmg_pkg::OP_THR1: begin
				mh_q <= 48'(draw_q) * 48'(acc_q[47:32]);
				ml_q <= 64'(draw_q) * 64'(acc_q[31:0]);
			end
			gmg_pkg::OP_THR2: thr_q <= (gmg_pkg::W48 + 1)'(mh_q) + 49'(ml_q[63:32]);
			gmg_pkg::OP_SC_CMP: t_cur_q <= k_q;
			gmg_pkg::OP_OUT: begin
				res_topic <= gmg_pkg::TOPIC_W'(32'(t_cur_q));
				res_under <= under_q;
			end
			default: ;
		endcase
	end

	// control registers
	logic under_q, out_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			k_q         <= '0;
			acc_q       <= '0;
			under_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr) clr_q <= clr_q + 1'b1;
			case (op)
				gmg_pkg::OP_CAPTURE: under_q <= 1'b0;
				gmg_pkg::OP_REM_WR: begin
					under_q <= (doc_rd_q == '0) || (dep_rd_q == '0) || (gov_rd_q == '0)
						|| (dtot_rd_q == '0) || (gtot_rd_q == '0);
					k_q   <= '0;
					acc_q <= '0;
				end
				gmg_pkg::OP_ACC: begin
					acc_q <= acc_new;
					if (k_q != kmax_q) k_q <= k_q + 1'b1;
				end
				gmg_pkg::OP_THR2: k_q <= '0;
				gmg_pkg::OP_SC_CMP: begin
					if (!status.hit && k_q != kmax_q) k_q <= k_q + 1'b1;
				end
				default: ;
			endcase
			if (op == gmg_pkg::OP_OUT)             out_valid_q <= 1'b1;
			else if (res_ready)                    out_valid_q <= 1'b0;
		end
	end

	assign res_valid = out_valid_q;

	always_comb begin
		status.clr_last = (clr_q == CLRW'(CLR_LEN - 1));
		status.mode     = mode_q;
		status.div_done = done_d && done_g;
		status.k_last   = (k_q == kmax_q);
		status.hit      = ({1'b0, cw_rd_q} > thr_q);
		status.out_free = !out_valid_q || res_ready;
	end
endmodule

// File: hdl/topic_model_gibbs_sampler.sv
// Top level: collapsed Gibbs sampler for a two-vocabulary topic model.
`timescale 1ns / 1ps
// After reset the block sweeps its count tables to zero, one entry of each table
// a cycle, over MAX_TOPICS * max(MAX_DOCS, DEP_VOCAB, GOV_VOCAB) entries (262144 at
// the defaults); token.ready stays low meanwhile, configuration writes are taken.
// One token is worked at a time. An init token (mode 0) adds its counts and
// returns its clamped topic. A resample token removes its counts under the old
// topic; then each of the K topics in use needs two Q1.16 ratios (at most 1.0)
// from a pair of 16-step restoring dividers, which set the per-topic time, then
// two multiplies and a saturating accumulate into a cumulative-weight RAM; the
// draw is then scaled by the total and the RAM scanned for the first weight
// above it. Results sit in an output register, so the next token may be taken
// while a result still waits.
module topic_model_gibbs_sampler #(
	parameter int MAX_TOPICS  = gmg_pkg::MAX_TOPICS_DEF,
	parameter int MAX_DOCS    = gmg_pkg::MAX_DOCS_DEF,
	parameter int DEP_VOCAB   = gmg_pkg::DEP_VOCAB_DEF,
	parameter int GOV_VOCAB   = gmg_pkg::GOV_VOCAB_DEF,
	parameter int COUNT_WIDTH = gmg_pkg::COUNT_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	gmg_token_if.sink                  token,
	gmg_result_if.source               result,
	input  logic                       cfg_we,
	input  logic [gmg_pkg::CFG_IW-1:0] cfg_index,
	input  logic [gmg_pkg::CFG_DW-1:0] cfg_wdata
);
	gmg_pkg::gmg_cmd_t    cmd;
	gmg_pkg::gmg_status_t status;
	logic                 tok_ready;

	assign token.ready = tok_ready;

	// sequencer
	gmg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.tok_valid(token.valid), .tok_ready(tok_ready),
		.status(status), .cmd(cmd)
	);

	// tables and arithmetic
	gmg_datapath #(
		.MAX_TOPICS(MAX_TOPICS), .MAX_DOCS(MAX_DOCS), .DEP_VOCAB(DEP_VOCAB),
		.GOV_VOCAB(GOV_VOCAB), .COUNT_WIDTH(COUNT_WIDTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.tok_mode(token.mode), .tok_doc(token.doc_index),
		.tok_dep(token.dependent_word), .tok_gov(token.governor_word),
		.tok_topic(token.current_topic), .tok_draw(token.random_draw),
		.res_valid(result.valid), .res_ready(result.ready),
		.res_topic(result.new_topic), .res_under(result.underflow)
	);
endmodule

// File: hdl/gmg_checker.sv
// Checker on the top-level ports, bound to the sampler.
`timescale 1ns / 1ps
module gmg_checker (
	input logic clk,
	input logic arst_n,
	input logic tok_valid,
	input logic tok_ready,
	input logic res_valid,
	input logic res_ready
);
	// a waiting result is not withdrawn
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn while stalled");

	// one token at a time: no new token the cycle after one is taken
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_ready |=> !tok_ready)
		else $error("token taken while another is in work");

	// no result can appear in the cycle straight after a token is taken
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_ready |=> !$rose(res_valid))
		else $error("result too early");

	// the table sweep holds off tokens right after reset
	a_clear_pass: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !tok_ready)
		else $error("token accepted during table sweep");
endmodule

bind topic_model_gibbs_sampler gmg_checker u_gmg_checker (
	.clk(clk), .arst_n(arst_n),
	.tok_valid(token.valid), .tok_ready(token.ready),
	.res_valid(result.valid), .res_ready(result.ready)
);

// File: test/tb_top.sv
// Testbench top: randomised token traffic against a predictor of the Gibbs sampler.
`timescale 1ns / 1ps
module tb_top;
	import gmg_pkg::*;

	localparam longint unsigned CNT_SAT  = (64'd1 << COUNT_WIDTH_DEF) - 1;
	localparam longint unsigned TOT_SAT  = 64'hFF_FFFF;
	localparam longint unsigned W48_SAT  = (64'd1 << 48) - 1;
	localparam int              NDOC     = MAX_DOCS_DEF;
	localparam int              NTOP     = MAX_TOPICS_DEF;
	localparam int              NDEP     = DEP_VOCAB_DEF;
	localparam int              NGOV     = GOV_VOCAB_DEF;
	// clearing sweep plus a worst case well above the planned traffic
	localparam longint          CYCLE_LIMIT = 6_000_000;

	typedef struct {
		bit                mode;
		bit [DOC_W-1:0]    doc;
		bit [WORD_W-1:0]   dep;
		bit [WORD_W-1:0]   gov;
		bit [TOPIC_W-1:0]  topic;
		bit [DRAW_W-1:0]   draw;
		bit                typed;     // expectation typed in the row itself
		bit [TOPIC_W-1:0]  exp_topic;
		bit                exp_uf;
	} token_row_t;

	typedef struct {
		bit [TOPIC_W-1:0] topic;
		bit               uf;
	} outcome_t;

	typedef struct {
		bit [DOC_W-1:0]   doc;
		bit [WORD_W-1:0]  dep;
		bit [WORD_W-1:0]  gov;
		bit [TOPIC_W-1:0] topic;
	} corpus_tok_t;

	typedef struct {
		bit [23:0] alpha, bdep, bgov;
		bit [6:0]  ntop;
		bit [12:0] vdep, vgov;
		int        items;
	} phase_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_wdata;

	gmg_token_if  tok_ch ();
	gmg_result_if res_ch ();

	topic_model_gibbs_sampler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.token     (tok_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// mirror of the sampler's registers and count tables
	bit [23:0] m_alpha = 24'd65536, m_bdep = 24'd6554, m_bgov = 24'd6554;
	bit [6:0]  m_ntop = 7'd64;
	bit [12:0] m_vdep = 13'd4096, m_vgov = 13'd4096;
	int unsigned doc_cnt [NDOC*NTOP];
	int unsigned dep_cnt [NTOP*NDEP];
	int unsigned gov_cnt [NTOP*NGOV];
	int unsigned dep_tot [NTOP];
	int unsigned gov_tot [NTOP];

	outcome_t    awaited_topics [$];
	corpus_tok_t corpus [$];
	int          mismatches = 0;
	longint      cycles = 0;
	bit [15:0]   stall_pat = 16'hFFFF;
	int          stall_pos = 0;

	// 8 ns clock
	always begin
		clk = 1'b0; #4;
		clk = 1'b1; #4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: stalls follow a rotating 16-bit pattern, redrawn per phase
	always @(negedge clk) begin
		res_ch.ready <= stall_pat[stall_pos];
		stall_pos    <= (stall_pos + 1) % 16;
	end

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			outcome_t e;
			if (awaited_topics.size() == 0) begin
				flag_mismatch($sformatf("unexpected result topic %0d", res_ch.new_topic));
			end else begin
				e = awaited_topics.pop_front();
				if (res_ch.new_topic !== e.topic)
					flag_mismatch($sformatf("new_topic %0d, wanted %0d",
						res_ch.new_topic, e.topic));
				if (res_ch.underflow !== e.uf)
					flag_mismatch($sformatf("underflow %0b, wanted %0b",
						res_ch.underflow, e.uf));
			end
		end
	end

	function automatic bit take_one(ref int unsigned c);
		if (c == 0) return 1'b1;
		c--;
		return 1'b0;
	endfunction

	function automatic void give_one(ref int unsigned c, input longint unsigned sat);
		if (c < sat) c++;
	endfunction

	function automatic longint unsigned q16_ratio(input longint unsigned cnt,
			input longint unsigned tot, input longint unsigned beta,
			input longint unsigned vsize);
		longint unsigned num, den;
		num = (cnt << 16) + beta;
		den = (tot << 16) + vsize * beta;
		if (den == 0) return 0;
		if (num >= den) return 64'd65536;
		return (num << 16) / den;
	endfunction

	function automatic void add_counts(int unsigned d, int unsigned w, int unsigned g,
			int unsigned k);
		give_one(doc_cnt[d*NTOP + k], CNT_SAT);
		give_one(dep_cnt[k*NDEP + w], CNT_SAT);
		give_one(gov_cnt[k*NGOV + g], CNT_SAT);
		give_one(dep_tot[k], TOT_SAT);
		give_one(gov_tot[k], TOT_SAT);
	endfunction

	// Works out the topic drawn for one token and updates the mirrored tables.
	function automatic outcome_t sample_topic(token_row_t r);
		int unsigned kn, t0, k, d, w, g;
		longint unsigned rd, rg, p, dn, wt, acc, thr, draw;
		longint unsigned cum [NTOP];
		outcome_t o;
		kn = m_ntop;
		if (kn < 1) kn = 1;
		if (kn > NTOP) kn = NTOP;
		t0 = r.topic;
		if (t0 >= kn) t0 = kn - 1;
		d = r.doc % NDOC;
		w = r.dep % NDEP;
		g = r.gov % NGOV;
		o.uf = 1'b0;
		if (!r.mode) begin
			add_counts(d, w, g, t0);
			o.topic = t0;
			return o;
		end
		// remove the token under its old topic; each counter saturates on its own
		o.uf |= take_one(doc_cnt[d*NTOP + t0]);
		o.uf |= take_one(dep_cnt[t0*NDEP + w]);
		o.uf |= take_one(gov_cnt[t0*NGOV + g]);
		o.uf |= take_one(dep_tot[t0]);
		o.uf |= take_one(gov_tot[t0]);
		acc = 0;
		for (k = 0; k < kn; k++) begin
			rd = q16_ratio(dep_cnt[k*NDEP + w], dep_tot[k], m_bdep, m_vdep);
			rg = q16_ratio(gov_cnt[k*NGOV + g], gov_tot[k], m_bgov, m_vgov);
			p  = (rd * rg) >> 16;
			dn = (longint'(doc_cnt[d*NTOP + k]) << 16) + m_alpha;
			wt = p * (dn >> 16) + ((p * (dn & 64'hFFFF)) >> 16);
			if (wt > W48_SAT) wt = W48_SAT;
			acc += wt;
			if (acc > W48_SAT) acc = W48_SAT;
			cum[k] = acc;
		end
		draw = r.draw;
		thr  = draw * (acc >> 32) + ((draw * (acc & 64'hFFFF_FFFF)) >> 32);
		// zero total weight falls through to the last topic in use
		o.topic = kn - 1;
		for (k = 0; k < kn; k++) begin
			if (cum[k] > thr) begin
				o.topic = k;
				break;
			end
		end
		add_counts(d, w, g, o.topic);
		return o;
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input bit [CFG_DW-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_ALPHA:     m_alpha = val[23:0];
			CFG_BETA_DEP:  m_bdep  = val[23:0];
			CFG_BETA_GOV:  m_bgov  = val[23:0];
			CFG_NUM_TOP:   m_ntop  = val[6:0];
			CFG_DEP_VSIZE: m_vdep  = val[12:0];
			CFG_GOV_VSIZE: m_vgov  = val[12:0];
			default: ;
		endcase
	endtask

	task automatic load_phase(input phase_t ph);
		write_reg(CFG_ALPHA, ph.alpha);
		write_reg(CFG_BETA_DEP, ph.bdep);
		write_reg(CFG_BETA_GOV, ph.bgov);
		write_reg(CFG_NUM_TOP, ph.ntop);
		write_reg(CFG_DEP_VSIZE, ph.vdep);
		write_reg(CFG_GOV_VSIZE, ph.vgov);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drives one token from the next falling edge, holds it until taken, then
	// books its expected outcome. valid is left high for the caller to drop.
	task automatic send_token(input token_row_t r, output outcome_t o);
		@(negedge clk);
		tok_ch.valid          <= 1'b1;
		tok_ch.mode           <= r.mode;
		tok_ch.doc_index      <= r.doc;
		tok_ch.dependent_word <= r.dep;
		tok_ch.governor_word  <= r.gov;
		tok_ch.current_topic  <= r.topic;
		tok_ch.random_draw    <= r.draw;
		forever begin
			@(posedge clk);
			if (tok_ch.ready) break;
		end
		o = sample_topic(r);
		if (r.typed) begin
			o.topic = r.exp_topic;
			o.uf    = r.exp_uf;
		end
		awaited_topics.push_back(o);
	endtask

	task automatic drain();
		@(negedge clk);
		tok_ch.valid <= 1'b0;
		while (awaited_topics.size() != 0) @(posedge clk);
		repeat (30) @(negedge clk);
	endtask

	// Well-formed traffic mostly: new tokens on small document and word pools, then
	// resampling of tokens already placed with their current topic. The rest is
	// full-range noise, which also exercises removal from empty counters.
	function automatic token_row_t pick_token(output int src);
		token_row_t r;
		int sel;
		sel   = $urandom_range(99);
		r     = '{default: '0};
		r.draw = ($urandom_range(19) == 0) ? ($urandom_range(1) ? '1 : '0) : $urandom;
		src   = -1;
		if (corpus.size() < 8 || sel < 30) begin
			r.mode = 1'b0;
			if ($urandom_range(6) == 0) begin
				r.doc = $urandom; r.dep = $urandom; r.gov = $urandom;
			end else begin
				r.doc = $urandom_range(7);
				r.dep = $urandom_range(15);
				r.gov = $urandom_range(15);
			end
			r.topic = $urandom_range(63);
			src = -2;
		end else if (sel < 90) begin
			src     = $urandom_range(corpus.size() - 1);
			r.mode  = 1'b1;
			r.doc   = corpus[src].doc;
			r.dep   = corpus[src].dep;
			r.gov   = corpus[src].gov;
			r.topic = corpus[src].topic;
		end else begin
			r.mode  = $urandom_range(1);
			r.doc   = $urandom; r.dep = $urandom; r.gov = $urandom;
			r.topic = $urandom;
		end
		return r;
	endfunction

	token_row_t directed [] = '{
		// empty tables: every removal underflows, all weights round to zero
		'{1, 0, 0, 0, 0, 32'h0, 1, 63, 1},
		'{0, 1023, 4095, 4095, 63, 32'hFFFF_FFFF, 1, 63, 0},
		'{0, 0, 0, 0, 0, 32'h0, 1, 0, 0},
		'{0, 0, 0, 0, 5, 32'h1234_5678, 1, 5, 0},
		'{0, 512, 2048, 1, 31, 32'hAAAA_AAAA, 1, 31, 0},
		'{1, 0, 0, 0, 5, 32'h0, 0, 0, 0},
		'{1, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0},
		'{1, 1023, 4095, 4095, 63, 32'h8000_0000, 0, 0, 0},
		'{1, 512, 2048, 1, 31, 32'h5555_5555, 0, 0, 0},
		'{1, 7, 3, 9, 40, 32'h0000_0001, 0, 0, 0}
	};

	// small topic counts keep most resamples short; a few phases take the extremes
	phase_t phases [] = '{
		'{24'd65536, 24'd6554, 24'd6554, 7'd4, 13'd4096, 13'd4096, 300},
		'{24'd0, 24'd6554, 24'd6554, 7'd8, 13'd100, 13'd100, 150},
		'{24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 7'd3, 13'd8191, 13'd8191, 120},
		'{24'd1000, 24'd0, 24'd0, 7'd5, 13'd0, 13'd0, 100},
		'{24'd65536, 24'd1, 24'd65536, 7'd0, 13'd1, 13'd1, 80},
		'{24'd30000, 24'd6554, 24'd20000, 7'd127, 13'd4096, 13'd50, 25},
		'{24'd65536, 24'd300, 24'd9000, 7'd2, 13'd8191, 13'd0, 200},
		'{24'd500000, 24'd6554, 24'd6554, 7'd16, 13'd200, 13'd4096, 200},
		'{24'd65536, 24'd6554, 24'd6554, 7'd6, 13'd4096, 13'd4096, 225}
	};

	initial begin
		token_row_t r;
		outcome_t   o;
		int         src, burst, gap;
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = CFG_ALPHA;
		cfg_wdata             = '0;
		tok_ch.valid          = 1'b0;
		tok_ch.mode           = 1'b0;
		tok_ch.doc_index      = '0;
		tok_ch.dependent_word = '0;
		tok_ch.governor_word  = '0;
		tok_ch.current_topic  = '0;
		tok_ch.random_draw    = '0;
		res_ch.ready          = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rows run at the reset settings
		foreach (directed[i]) begin
			send_token(directed[i], o);
			if (i % 3 == 2) begin
				@(negedge clk);
				tok_ch.valid <= 1'b0;
			end
		end
		drain();

		foreach (phases[p]) begin
			load_phase(phases[p]);
			stall_pat = ($urandom_range(2) == 0) ? 16'hFFFF : ($urandom | 16'h0101);
			burst = 0;
			for (int n = 0; n < phases[p].items; n++) begin
				r = pick_token(src);
				send_token(r, o);
				if (src >= 0) corpus[src].topic = o.topic;
				else if (src == -2) begin
					if (corpus.size() >= 300) corpus.delete($urandom_range(299));
					corpus.push_back('{r.doc, r.dep, r.gov, o.topic});
				end
				if (burst == 0) begin
					burst = $urandom_range(12);
					gap   = $urandom_range(1, 6);
					@(negedge clk);
					tok_ch.valid <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end else begin
					burst--;
				end
			end
			// sender holds off until the pipeline is empty before reconfiguring
			drain();
		end

		while (awaited_topics.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
